/* hw/rtl/prtg_pkg.sv */
// ----------------------------------------------------------------------------
// Ramped pulse train generator package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package prtg_pkg;

  localparam int unsigned TimeBitsDefault = 16;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FIRST_ON_WIDTH = 3'd0,
    CFG_LAST_ON_WIDTH  = 3'd1,
    CFG_WIDTH_STEP     = 3'd2,
    CFG_OFF_WIDTH      = 3'd3,
    CFG_GAP_WIDTH      = 3'd4,
    CFG_SYNC_WIDTH     = 3'd5,
    CFG_DEBOUNCE_TICKS = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] FirstOnWidthReset  = 16'd800;
  localparam logic [15:0] LastOnWidthReset   = 16'd1550;
  localparam logic [11:0] WidthStepReset     = 12'd50;
  localparam logic [15:0] OffWidthReset      = 16'd1200;
  localparam logic [15:0] GapWidthReset      = 16'd6000;
  localparam logic [9:0]  SyncWidthReset     = 10'd50;
  localparam logic [9:0]  DebounceTicksReset = 10'd50;

  typedef struct packed {
    logic [15:0] first_on_width;
    logic [15:0] last_on_width;
    logic [11:0] width_step;
    logic [15:0] off_width;
    logic [15:0] gap_width;
    logic [9:0]  sync_width;
  } timing_cfg_t;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

endpackage

/* hw/rtl/prtg_debounce.sv */
// ----------------------------------------------------------------------------
// Button debounce and toggle flag
// Confirms a rising edge after a programmable delay and toggles the flag.
// ----------------------------------------------------------------------------
module prtg_debounce #(
  parameter logic FlagReset = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic       level_i,
  input  logic [9:0] debounce_ticks_i,
  output logic       flag_o
);

  logic [9:0] cnt_q, cnt_d;
  logic       prev_q;
  logic       flag_q, flag_d;
  logic       toggle;

  always_comb begin
    cnt_d  = cnt_q;
    toggle = 1'b0;
    if (cnt_q == 10'd0) begin
      if (level_i && !prev_q) begin
        if (debounce_ticks_i == 10'd0) begin
          toggle = 1'b1;
        end else begin
          cnt_d = debounce_ticks_i;
        end
      end
    end else begin
      cnt_d  = cnt_q - 10'd1;
      toggle = (cnt_q == 10'd1) && level_i;
    end
    flag_d = flag_q ^ toggle;
  end

  assign flag_o = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= 1'b0;
      flag_q <= FlagReset;
    end else if (tick_i) begin
      cnt_q  <= cnt_d;
      prev_q <= level_i;
      flag_q <= flag_d;
    end
  end

endmodule

/* hw/rtl/prtg_sequencer.sv */
// ----------------------------------------------------------------------------
// Pulse train sequencer
// Steps through sync, pulse high, pulse low and gap phases once per tick.
// ----------------------------------------------------------------------------
module prtg_sequencer #(
  parameter int unsigned TimeBits = prtg_pkg::TimeBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,
  input  prtg_pkg::timing_cfg_t cfg_i,
  input  logic                  enable_flag_i,
  input  logic                  select_flag_i,
  output logic                  sync_o,
  output logic                  pulse_o
);

  localparam logic [31:0] TimeMax = 32'((64'd1 << TimeBits) - 64'd1);

  function automatic logic [TimeBits-1:0] load_time(input logic [15:0] v);
    logic [31:0] w;
    begin
      w = {16'd0, v};
      if (w == 32'd0) begin
        w = 32'd1;
      end
      if (w > TimeMax) begin
        w = TimeMax;
      end
      return w[TimeBits-1:0];
    end
  endfunction

  prtg_pkg::phase_e     phase_q, phase_d;
  logic [TimeBits-1:0]  time_left_q, time_left_d;
  logic [15:0]          cur_w_q, cur_w_d;
  logic                 ramp_up_q, ramp_up_d;
  logic                 pulse_level_q, pulse_level_d;

  logic [11:0]          step;
  logic [16:0]          next_up;
  logic [16:0]          down_floor;
  logic                 go_on;
  logic                 go_gap;
  logic [15:0]          on_w;

  always_comb begin
    phase_d       = phase_q;
    time_left_d   = time_left_q;
    cur_w_d       = cur_w_q;
    ramp_up_d     = ramp_up_q;
    pulse_level_d = pulse_level_q;
    go_on         = 1'b0;
    go_gap        = 1'b0;
    on_w          = cur_w_q;

    step       = (cfg_i.width_step == 12'd0) ? 12'd1 : cfg_i.width_step;
    next_up    = {1'b0, cur_w_q} + {5'd0, step};
    down_floor = {1'b0, cfg_i.first_on_width} + {5'd0, step};

    if (time_left_q == '0) begin
      phase_d       = prtg_pkg::PH_SYNC;
      ramp_up_d     = select_flag_i;
      pulse_level_d = 1'b0;
      time_left_d   = load_time({6'd0, cfg_i.sync_width});
    end

    sync_o  = (phase_d == prtg_pkg::PH_SYNC);
    pulse_o = (phase_d == prtg_pkg::PH_ON) && pulse_level_d;

    time_left_d = time_left_d - TimeBits'(1);

    if (time_left_d == '0) begin
      unique case (phase_d)
        prtg_pkg::PH_SYNC: begin
          on_w = ramp_up_d ? cfg_i.first_on_width : cfg_i.last_on_width;
          if (cfg_i.first_on_width <= cfg_i.last_on_width) begin
            go_on = 1'b1;
          end else begin
            go_gap = 1'b1;
          end
        end
        prtg_pkg::PH_ON: begin
          phase_d       = prtg_pkg::PH_OFF;
          pulse_level_d = 1'b0;
          time_left_d   = load_time(cfg_i.off_width);
        end
        prtg_pkg::PH_OFF: begin
          if (ramp_up_d) begin
            if (next_up <= {1'b0, cfg_i.last_on_width}) begin
              on_w  = next_up[15:0];
              go_on = 1'b1;
            end else begin
              go_gap = 1'b1;
            end
          end else begin
            if ({1'b0, cur_w_q} >= down_floor) begin
              on_w  = cur_w_q - {4'd0, step};
              go_on = 1'b1;
            end else begin
              go_gap = 1'b1;
            end
          end
        end
        prtg_pkg::PH_GAP: begin
          phase_d       = prtg_pkg::PH_SYNC;
          ramp_up_d     = select_flag_i;
          pulse_level_d = 1'b0;
          time_left_d   = load_time({6'd0, cfg_i.sync_width});
        end
        default: begin
          phase_d = prtg_pkg::PH_SYNC;
        end
      endcase

      if (go_on) begin
        cur_w_d       = on_w;
        phase_d       = prtg_pkg::PH_ON;
        time_left_d   = load_time(on_w);
        pulse_level_d = enable_flag_i;
      end else if (go_gap) begin
        cur_w_d       = on_w;
        pulse_level_d = 1'b0;
        if (cfg_i.gap_width == 16'd0) begin
          phase_d     = prtg_pkg::PH_SYNC;
          ramp_up_d   = select_flag_i;
          time_left_d = load_time({6'd0, cfg_i.sync_width});
        end else begin
          phase_d     = prtg_pkg::PH_GAP;
          time_left_d = load_time(cfg_i.gap_width);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= prtg_pkg::PH_SYNC;
      time_left_q   <= '0;
      cur_w_q       <= '0;
      ramp_up_q     <= 1'b1;
      pulse_level_q <= 1'b0;
    end else if (tick_i) begin
      phase_q       <= phase_d;
      time_left_q   <= time_left_d;
      cur_w_q       <= cur_w_d;
      ramp_up_q     <= ramp_up_d;
      pulse_level_q <= pulse_level_d;
    end
  end

endmodule

/* hw/rtl/ramped_pulse_train_generator_unit.sv */
// ----------------------------------------------------------------------------
// Ramped pulse train generator
// Per-tick sync and ramped pulse outputs with debounced button toggles.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one microsecond tick carrying the
// sampled enable and select button levels. Each tick gives exactly one
// transfer on the output channel with the sync and pulse levels for it.
// The tick is captured in an input register; when it advances, the debounce
// counters, flags and phase sequencer step and the result is written to
// the output register. One tick is taken every cycle while the output is
// not stalled. When the receiver stalls, the output holds its result and
// the input stall rises as soon as the input register holds a tick.
// The user must write configuration through the write port only while no
// tick is in flight; the block does not enforce this. Index values beyond
// the register list are ignored.
// Reset clears the pipeline, loads the default timing registers and leaves
// the sequencer ready to start a cycle with a sync pulse on the first tick.
// ----------------------------------------------------------------------------
module ramped_pulse_train_generator_unit #(
  parameter int unsigned TimeBits = prtg_pkg::TimeBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             enable_level_i,
  input  logic                             select_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             sync_out_o,
  output logic                             pulse_out_o,
  input  logic                             cfg_we_i,
  input  logic [prtg_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [prtg_pkg::CfgDataBits-1:0] cfg_wdata_i
);

  prtg_pkg::timing_cfg_t cfg_q;
  logic [9:0]            debounce_ticks_q;

  logic in_valid_q;
  logic enable_level_q, select_level_q;
  logic out_valid_q;
  logic sync_q, pulse_q;
  logic advance;
  logic enable_flag, select_flag;
  logic sync_d, pulse_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_on_width <= prtg_pkg::FirstOnWidthReset;
      cfg_q.last_on_width  <= prtg_pkg::LastOnWidthReset;
      cfg_q.width_step     <= prtg_pkg::WidthStepReset;
      cfg_q.off_width      <= prtg_pkg::OffWidthReset;
      cfg_q.gap_width      <= prtg_pkg::GapWidthReset;
      cfg_q.sync_width     <= prtg_pkg::SyncWidthReset;
      debounce_ticks_q     <= prtg_pkg::DebounceTicksReset;
    end else if (cfg_we_i) begin
      unique case (prtg_pkg::cfg_idx_e'(cfg_idx_i))
        prtg_pkg::CFG_FIRST_ON_WIDTH: cfg_q.first_on_width <= cfg_wdata_i;
        prtg_pkg::CFG_LAST_ON_WIDTH:  cfg_q.last_on_width  <= cfg_wdata_i;
        prtg_pkg::CFG_WIDTH_STEP:     cfg_q.width_step     <= cfg_wdata_i[11:0];
        prtg_pkg::CFG_OFF_WIDTH:      cfg_q.off_width      <= cfg_wdata_i;
        prtg_pkg::CFG_GAP_WIDTH:      cfg_q.gap_width      <= cfg_wdata_i;
        prtg_pkg::CFG_SYNC_WIDTH:     cfg_q.sync_width     <= cfg_wdata_i[9:0];
        prtg_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q     <= cfg_wdata_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      enable_level_q <= enable_level_i;
      select_level_q <= select_level_i;
    end
  end

  prtg_debounce #(
    .FlagReset (1'b0)
  ) u_enable_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (advance),
    .level_i          (enable_level_q),
    .debounce_ticks_i (debounce_ticks_q),
    .flag_o           (enable_flag)
  );

  prtg_debounce #(
    .FlagReset (1'b1)
  ) u_select_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (advance),
    .level_i          (select_level_q),
    .debounce_ticks_i (debounce_ticks_q),
    .flag_o           (select_flag)
  );

  prtg_sequencer #(
    .TimeBits (TimeBits)
  ) u_sequencer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (advance),
    .cfg_i         (cfg_q),
    .enable_flag_i (enable_flag),
    .select_flag_i (select_flag),
    .sync_o        (sync_d),
    .pulse_o       (pulse_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sync_q  <= sync_d;
      pulse_q <= pulse_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sync_out_o  = sync_q;
  assign pulse_out_o = pulse_q;

endmodule
